// ===== design/nsp_pkg.sv =====
// ----------------------------------------------------------------------------
// nsp_pkg
// Shared types, constants and helper functions of the NMEA sentence parser.
// ----------------------------------------------------------------------------
package nsp_pkg;

	// sentence-type characters kept per sentence
	localparam int TYPE_CHARS = 3;
	// type register, never narrower than the 24 reported bits
	localparam int TYPE_W     = (TYPE_CHARS > 3) ? 8 * TYPE_CHARS : 24;
	// data field limit of the field counter
	localparam int MAX_FIELDS = 64;
	localparam int FIELD_CAP  = (MAX_FIELDS > 127) ? 127 : MAX_FIELDS;

	// framing characters
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;

	// known sentence types, first character in the high byte
	localparam logic [23:0] TYPE_GGA = 24'h474741;
	localparam logic [23:0] TYPE_RMC = 24'h524D43;
	localparam logic [23:0] TYPE_GSA = 24'h475341;
	localparam logic [23:0] TYPE_GSV = 24'h475356;
	localparam logic [23:0] TYPE_VTG = 24'h565447;

	// parser phase
	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_TALK1 = 3'd1,
		PH_TALK2 = 3'd2,
		PH_TYPE  = 3'd3,
		PH_DATA  = 3'd4,
		PH_SUM1  = 3'd5,
		PH_SUM2  = 3'd6
	} phase_t;

	// kind of a result beat
	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_FIELD = 2'd1,
		KIND_END   = 2'd2
	} kind_t;

	// sentence type codes
	typedef enum logic [2:0] {
		TC_UNKNOWN = 3'd0,
		TC_GGA     = 3'd1,
		TC_RMC     = 3'd2,
		TC_GSA     = 3'd3,
		TC_GSV     = 3'd4,
		TC_VTG     = 3'd5
	} type_code_t;

	// one result beat
	typedef struct packed {
		kind_t       kind;
		logic [7:0]  char_value;
		logic [5:0]  field_index;
		logic [15:0] talker_code;
		logic [23:0] type_chars;
		logic [3:0]  type_length;
		type_code_t  type_code;
		logic [6:0]  field_count;
		logic        checksum_ok;
		logic [7:0]  sum_computed;
		logic [7:0]  sum_received;
	} result_t;

	// hex digit value, anything else counts as zero
	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 4'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = 4'(c - 8'h57);
		end
		return v;
	endfunction

	// sentence type code from stored type characters
	function automatic type_code_t type_code_of(input logic [TYPE_W-1:0] t,
			input logic [3:0] len);
		type_code_t tc;
		tc = TC_UNKNOWN;
		if (len == 4'd3 && t == TYPE_W'(t[23:0])) begin
			if (t[23:0] == TYPE_GGA)      tc = TC_GGA;
			else if (t[23:0] == TYPE_RMC) tc = TC_RMC;
			else if (t[23:0] == TYPE_GSA) tc = TC_GSA;
			else if (t[23:0] == TYPE_GSV) tc = TC_GSV;
			else if (t[23:0] == TYPE_VTG) tc = TC_VTG;
		end
		return tc;
	endfunction

endpackage

// ===== design/nsp_rx_if.sv =====
// ----------------------------------------------------------------------------
// nsp_rx_if
// Byte channel into the parser: valid, ready and one received character.
// ----------------------------------------------------------------------------
interface nsp_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== design/nsp_res_if.sv =====
// ----------------------------------------------------------------------------
// nsp_res_if
// Result channel out of the parser: valid, ready and one result beat.
// ----------------------------------------------------------------------------
interface nsp_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  char_value;
	logic [5:0]  field_index;
	logic [15:0] talker_code;
	logic [23:0] type_chars;
	logic [3:0]  type_length;
	logic [2:0]  type_code;
	logic [6:0]  field_count;
	logic        checksum_ok;
	logic [7:0]  sum_computed;
	logic [7:0]  sum_received;

	modport source (output valid, input ready, output kind, output char_value,
		output field_index, output talker_code, output type_chars,
		output type_length, output type_code, output field_count,
		output checksum_ok, output sum_computed, output sum_received);
	modport sink (input valid, output ready, input kind, input char_value,
		input field_index, input talker_code, input type_chars,
		input type_length, input type_code, input field_count,
		input checksum_ok, input sum_computed, input sum_received);
endinterface

// ===== design/nmea_sentence_parser.sv =====
// ----------------------------------------------------------------------------
// nmea_sentence_parser
// Frames NMEA 0183 sentences from a byte stream: streams data characters and
// field ends, then gives a sentence-end beat with header and checksum check.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                   handshake
//  rx       in   rx_byte                                   valid / ready
//  result   out  kind, char_value, field_index, talker,    valid / ready
//                type, field_count, checksum fields
//
//  One byte is taken per cycle while rx.ready is high; any result beat it
//  causes appears in the output register on the next cycle. Only parser
//  state and that register store; unstalled throughput is one byte per clock.
//  rx.ready is low only while a result beat waits and result.ready is low.
//  arst_n clears the parser to hunting and drops the output valid.
// ----------------------------------------------------------------------------
module nmea_sentence_parser
	import nsp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	nsp_rx_if.sink    rx,
	nsp_res_if.source result
);

	phase_t            phase_q, phase_d;
	logic [7:0]        xor_q, xor_d;
	logic [15:0]       talker_q, talker_d;
	logic [TYPE_W-1:0] type_q, type_d;
	logic [3:0]        type_cnt_q, type_cnt_d;
	logic [6:0]        fcnt_q, fcnt_d;
	logic [3:0]        sum_hi_q, sum_hi_d;

	logic              res_valid_q;
	result_t           res_q, res_d;
	logic              emit;
	logic              take;
	logic [7:0]        b;
	logic [5:0]        cur_index;
	logic [7:0]        recv;

	// accept while the output register is free or being drained
	assign rx.ready = !res_valid_q || result.ready;
	assign take     = rx.valid && rx.ready;
	assign b        = rx.rx_byte;

	// field index saturates at 63
	assign cur_index = (fcnt_q > 7'd63) ? 6'd63 : fcnt_q[5:0];
	assign recv      = {sum_hi_q, hex_value(b)};

	// next state of the parser
	always_comb begin
		phase_d    = phase_q;
		xor_d      = xor_q;
		talker_d   = talker_q;
		type_d     = type_q;
		type_cnt_d = type_cnt_q;
		fcnt_d     = fcnt_q;
		sum_hi_d   = sum_hi_q;
		unique case (phase_q)
			PH_HUNT: begin
				if (b == CH_DOLLAR) begin
					phase_d = PH_TALK1;
					xor_d   = 8'd0;
				end
			end
			PH_TALK1: begin
				talker_d = {b, 8'd0};
				xor_d    = xor_q ^ b;
				phase_d  = PH_TALK2;
			end
			PH_TALK2: begin
				talker_d   = {talker_q[15:8], b};
				xor_d      = xor_q ^ b;
				type_d     = '0;
				type_cnt_d = 4'd0;
				phase_d    = PH_TYPE;
			end
			PH_TYPE: begin
				xor_d = xor_q ^ b;
				if (b == CH_COMMA) begin
					fcnt_d  = 7'd0;
					phase_d = PH_DATA;
				end else begin
					if (32'(type_cnt_q) < TYPE_CHARS) begin
						type_d = {type_q[TYPE_W-9:0], b};
					end
					if (type_cnt_q != 4'd15) begin
						type_cnt_d = type_cnt_q + 4'd1;
					end
				end
			end
			PH_DATA: begin
				if (b == CH_STAR || b == CH_COMMA) begin
					if (b == CH_COMMA) begin
						xor_d = xor_q ^ b;
					end else begin
						phase_d = PH_SUM1;
					end
					if (32'(fcnt_q) < FIELD_CAP) begin
						fcnt_d = fcnt_q + 7'd1;
					end
				end else begin
					xor_d = xor_q ^ b;
				end
			end
			PH_SUM1: begin
				sum_hi_d = hex_value(b);
				phase_d  = PH_SUM2;
			end
			PH_SUM2: begin
				phase_d = PH_HUNT;
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	// result beat caused by this byte
	always_comb begin
		emit  = 1'b0;
		res_d = '0;
		unique case (phase_q)
			PH_DATA: begin
				emit              = 1'b1;
				res_d.field_index = cur_index;
				if (b == CH_STAR || b == CH_COMMA) begin
					res_d.kind = KIND_FIELD;
				end else begin
					res_d.kind       = KIND_DATA;
					res_d.char_value = b;
				end
			end
			PH_SUM2: begin
				emit               = 1'b1;
				res_d.kind         = KIND_END;
				res_d.talker_code  = talker_q;
				res_d.type_chars   = type_q[23:0];
				res_d.type_length  = type_cnt_q;
				res_d.type_code    = type_code_of(type_q, type_cnt_q);
				res_d.field_count  = fcnt_q;
				res_d.checksum_ok  = (recv == xor_q);
				res_d.sum_computed = xor_q;
				res_d.sum_received = recv;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			xor_q      <= 8'd0;
			talker_q   <= 16'd0;
			type_q     <= '0;
			type_cnt_q <= 4'd0;
			fcnt_q     <= 7'd0;
			sum_hi_q   <= 4'd0;
		end else if (take) begin
			phase_q    <= phase_d;
			xor_q      <= xor_d;
			talker_q   <= talker_d;
			type_q     <= type_d;
			type_cnt_q <= type_cnt_d;
			fcnt_q     <= fcnt_d;
			sum_hi_q   <= sum_hi_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rx.ready) begin
			res_valid_q <= take && emit;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (take && emit) begin
			res_q <= res_d;
		end
	end

	// drive the result channel
	assign result.valid        = res_valid_q;
	assign result.kind         = res_q.kind;
	assign result.char_value   = res_q.char_value;
	assign result.field_index  = res_q.field_index;
	assign result.talker_code  = res_q.talker_code;
	assign result.type_chars   = res_q.type_chars;
	assign result.type_length  = res_q.type_length;
	assign result.type_code    = res_q.type_code;
	assign result.field_count  = res_q.field_count;
	assign result.checksum_ok  = res_q.checksum_ok;
	assign result.sum_computed = res_q.sum_computed;
	assign result.sum_received = res_q.sum_received;

endmodule
